/* rtl/dpfe_pkg.sv */
package dpfe_pkg;

	localparam int HOSTNAME_MAX_DEF = 63;
	localparam int HN_CNT_W = 6;

	localparam logic [15:0] SERVER_PORT_RST = 16'd67;
	localparam logic [15:0] CLIENT_PORT_RST = 16'd68;

	localparam logic CFG_SERVER_PORT = 1'b0;
	localparam logic CFG_CLIENT_PORT = 1'b1;

	localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;

	localparam logic [7:0] POS_CIADDR_LO = 8'd12;
	localparam logic [7:0] POS_CIADDR_HI = 8'd15;
	localparam logic [7:0] POS_YIADDR_LO = 8'd16;
	localparam logic [7:0] POS_YIADDR_HI = 8'd19;
	localparam logic [7:0] POS_CHADDR_LO = 8'd28;
	localparam logic [7:0] POS_CHADDR_HI = 8'd33;
	localparam logic [7:0] POS_COOKIE_LO = 8'd236;
	localparam logic [7:0] POS_COOKIE_HI = 8'd239;
	localparam logic [7:0] POS_SAT = 8'd240;

	localparam logic [7:0] OPT_PAD = 8'd0;
	localparam logic [7:0] OPT_HOSTNAME = 8'd12;
	localparam logic [7:0] OPT_REQ_IP = 8'd50;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_END = 8'd255;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_PORTS = 3'd1;
	localparam logic [2:0] ST_TOO_SHORT = 3'd2;
	localparam logic [2:0] ST_BAD_COOKIE = 3'd3;
	localparam logic [2:0] ST_TRUNC_OPT = 3'd4;
	localparam logic [2:0] ST_ZERO_MAC = 3'd5;

	typedef struct packed {
		logic [2:0]          status;
		logic [47:0]         mac_address;
		logic [31:0]         ip_address;
		logic                ip_present;
		logic [7:0]          msg_type;
		logic                msg_type_present;
		logic                hostname_present;
		logic [7:0]          hostname_length;
		logic                hostname_truncated;
		logic [HN_CNT_W-1:0] hn_count;
		logic                bank;
	} summary_t;

	typedef struct packed {
		logic       en;
		logic       bank;
		logic [7:0] idx;
		logic [7:0] data;
	} hn_wr_t;

endpackage

/* rtl/dpfe_byte_if.sv */
interface dpfe_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic [15:0] src_port;
	logic [15:0] dest_port;

	modport source(output valid, data_byte, last_byte, src_port, dest_port, input ready);
	modport sink(input valid, data_byte, last_byte, src_port, dest_port, output ready);
endinterface

/* rtl/dpfe_result_if.sv */
interface dpfe_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [47:0] mac_address;
	logic [31:0] ip_address;
	logic        ip_present;
	logic [7:0]  msg_type;
	logic        msg_type_present;
	logic        hostname_present;
	logic [7:0]  hostname_length;
	logic        hostname_truncated;
	logic [7:0]  hostname_char;
	logic        is_summary;
	logic        last_of_run;

	modport source(output valid, status, mac_address, ip_address, ip_present, msg_type,
		msg_type_present, hostname_present, hostname_length, hostname_truncated,
		hostname_char, is_summary, last_of_run, input ready);
	modport sink(input valid, status, mac_address, ip_address, ip_present, msg_type,
		msg_type_present, hostname_present, hostname_length, hostname_truncated,
		hostname_char, is_summary, last_of_run, output ready);
endinterface

/* rtl/dpfe_front.sv */
module dpfe_front #(
	parameter int HOSTNAME_MAX = dpfe_pkg::HOSTNAME_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	dpfe_byte_if.sink          byte_ch,
	input  logic               q_not_full,
	output logic               push,
	output dpfe_pkg::summary_t push_data,
	output dpfe_pkg::hn_wr_t   hn_wr
);

	localparam logic [2:0] PH_HDR  = 3'd0;
	localparam logic [2:0] PH_CODE = 3'd1;
	localparam logic [2:0] PH_LEN  = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;
	localparam logic [2:0] PH_SKIP = 3'd5;

	localparam logic [7:0] HN_MAX8 = 8'(HOSTNAME_MAX);

	logic [15:0] srv_port_q, cli_port_q;
	logic [7:0]  pos_q;
	logic [2:0]  phase_q, phase_d, phase_cur;
	logic [7:0]  code_q, code_d, len_q, len_d, idx_q, idx_d;
	logic [31:0] shift_q, shift_d;
	logic [47:0] mac_q, mac_d;
	logic [31:0] yip_q, yip_d, cip_q, cip_d, rip_q, rip_d;
	logic        rip_ok_q, rip_ok_d;
	logic [7:0]  mt_q, mt_d;
	logic        mt_ok_q, mt_ok_d;
	logic        hn_seen_q, hn_seen_d;
	logic [7:0]  hn_len_q, hn_len_d;
	logic        hn_cut_q, hn_cut_d;
	logic [2:0]  status_q, status_d, status_fin;
	logic        bank_q;
	logic        acc;
	logic [7:0]  b;
	logic        last;
	logic        ports_ok;
	logic [7:0]  hn_n;

	assign byte_ch.ready = q_not_full;
	assign acc = byte_ch.valid && q_not_full;
	assign b = byte_ch.data_byte;
	assign last = byte_ch.last_byte;
	assign ports_ok = (byte_ch.src_port == srv_port_q || byte_ch.src_port == cli_port_q)
		&& (byte_ch.dest_port == srv_port_q || byte_ch.dest_port == cli_port_q);

	always_comb begin
		phase_d = phase_q;
		code_d = code_q;
		len_d = len_q;
		idx_d = idx_q;
		shift_d = shift_q;
		mac_d = mac_q;
		yip_d = yip_q;
		cip_d = cip_q;
		rip_d = rip_q;
		rip_ok_d = rip_ok_q;
		mt_d = mt_q;
		mt_ok_d = mt_ok_q;
		hn_seen_d = hn_seen_q;
		hn_len_d = hn_len_q;
		hn_cut_d = hn_cut_q;
		status_d = status_q;
		hn_wr = '0;
		hn_wr.bank = bank_q;
		hn_wr.idx = idx_q;
		hn_wr.data = b;

		if (pos_q == 8'd0 && !ports_ok) begin
			if (status_d == dpfe_pkg::ST_OK) status_d = dpfe_pkg::ST_BAD_PORTS;
			phase_d = PH_SKIP;
		end
		phase_cur = phase_d;

		unique case (phase_cur)
			PH_HDR: begin
				if (pos_q >= dpfe_pkg::POS_CIADDR_LO && pos_q <= dpfe_pkg::POS_CIADDR_HI)
					cip_d = {cip_q[23:0], b};
				else if (pos_q >= dpfe_pkg::POS_YIADDR_LO && pos_q <= dpfe_pkg::POS_YIADDR_HI)
					yip_d = {yip_q[23:0], b};
				else if (pos_q >= dpfe_pkg::POS_CHADDR_LO && pos_q <= dpfe_pkg::POS_CHADDR_HI)
					mac_d = {mac_q[39:0], b};
				else if (pos_q >= dpfe_pkg::POS_COOKIE_LO && pos_q <= dpfe_pkg::POS_COOKIE_HI)
					shift_d = {shift_q[23:0], b};
				if (pos_q == dpfe_pkg::POS_COOKIE_HI) begin
					if (shift_d != dpfe_pkg::MAGIC_COOKIE) begin
						if (status_d == dpfe_pkg::ST_OK) status_d = dpfe_pkg::ST_BAD_COOKIE;
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_CODE;
					end
				end else if (last) begin
					if (status_d == dpfe_pkg::ST_OK) status_d = dpfe_pkg::ST_TOO_SHORT;
					phase_d = PH_SKIP;
				end
			end
			PH_CODE: begin
				if (b == dpfe_pkg::OPT_END) begin
					phase_d = PH_DONE;
				end else if (b != dpfe_pkg::OPT_PAD) begin
					code_d = b;
					phase_d = PH_LEN;
					if (last) begin
						if (status_d == dpfe_pkg::ST_OK) status_d = dpfe_pkg::ST_TRUNC_OPT;
						phase_d = PH_SKIP;
					end
				end
			end
			PH_LEN: begin
				len_d = b;
				idx_d = 8'd0;
				shift_d = 32'd0;
				if (code_q == dpfe_pkg::OPT_HOSTNAME) begin
					hn_seen_d = 1'b1;
					hn_len_d = b;
					hn_cut_d = b > HN_MAX8;
				end
				if (b == 8'd0) begin
					phase_d = PH_CODE;
				end else begin
					phase_d = PH_DATA;
					if (last) begin
						if (status_d == dpfe_pkg::ST_OK) status_d = dpfe_pkg::ST_TRUNC_OPT;
						phase_d = PH_SKIP;
					end
				end
			end
			PH_DATA: begin
				hn_wr.en = acc && code_q == dpfe_pkg::OPT_HOSTNAME && idx_q < HN_MAX8;
				shift_d = {shift_q[23:0], b};
				idx_d = idx_q + 8'd1;
				if (idx_d == len_q) begin
					if (code_q == dpfe_pkg::OPT_REQ_IP && len_q == 8'd4 && !rip_ok_q) begin
						rip_d = shift_d;
						rip_ok_d = 1'b1;
					end else if (code_q == dpfe_pkg::OPT_MSG_TYPE && len_q == 8'd1) begin
						mt_d = b;
						mt_ok_d = 1'b1;
					end
					phase_d = PH_CODE;
				end else if (last) begin
					if (status_d == dpfe_pkg::ST_OK) status_d = dpfe_pkg::ST_TRUNC_OPT;
					phase_d = PH_SKIP;
				end
			end
			default: begin
			end
		endcase

		status_fin = (status_d == dpfe_pkg::ST_OK && mac_d == 48'd0) ?
			dpfe_pkg::ST_ZERO_MAC : status_d;
		hn_n = (hn_len_d < HN_MAX8) ? hn_len_d : HN_MAX8;

		push_data = '0;
		push_data.status = status_fin;
		push_data.bank = bank_q;
		if (status_fin == dpfe_pkg::ST_OK) begin
			push_data.mac_address = mac_d;
			if (yip_d != 32'd0) begin
				push_data.ip_address = yip_d;
				push_data.ip_present = 1'b1;
			end else if (cip_d != 32'd0) begin
				push_data.ip_address = cip_d;
				push_data.ip_present = 1'b1;
			end else if (rip_ok_d) begin
				push_data.ip_address = rip_d;
				push_data.ip_present = 1'b1;
			end
			push_data.msg_type = mt_d;
			push_data.msg_type_present = mt_ok_d;
			push_data.hostname_present = hn_seen_d;
			push_data.hostname_length = hn_len_d;
			push_data.hostname_truncated = hn_cut_d;
			push_data.hn_count = hn_seen_d ? dpfe_pkg::HN_CNT_W'(hn_n) : '0;
		end
	end

	assign push = acc && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srv_port_q <= dpfe_pkg::SERVER_PORT_RST;
			cli_port_q <= dpfe_pkg::CLIENT_PORT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpfe_pkg::CFG_SERVER_PORT: srv_port_q <= cfg_data;
				dpfe_pkg::CFG_CLIENT_PORT: cli_port_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= PH_HDR;
			code_q <= '0;
			len_q <= '0;
			idx_q <= '0;
			shift_q <= '0;
			mac_q <= '0;
			yip_q <= '0;
			cip_q <= '0;
			rip_q <= '0;
			rip_ok_q <= 1'b0;
			mt_q <= '0;
			mt_ok_q <= 1'b0;
			hn_seen_q <= 1'b0;
			hn_len_q <= '0;
			hn_cut_q <= 1'b0;
			status_q <= dpfe_pkg::ST_OK;
			bank_q <= 1'b0;
		end else if (acc && last) begin
			pos_q <= '0;
			phase_q <= PH_HDR;
			code_q <= '0;
			len_q <= '0;
			idx_q <= '0;
			shift_q <= '0;
			mac_q <= '0;
			yip_q <= '0;
			cip_q <= '0;
			rip_q <= '0;
			rip_ok_q <= 1'b0;
			mt_q <= '0;
			mt_ok_q <= 1'b0;
			hn_seen_q <= 1'b0;
			hn_len_q <= '0;
			hn_cut_q <= 1'b0;
			status_q <= dpfe_pkg::ST_OK;
			bank_q <= !bank_q;
		end else if (acc) begin
			pos_q <= (pos_q == dpfe_pkg::POS_SAT) ? pos_q : pos_q + 8'd1;
			phase_q <= phase_d;
			code_q <= code_d;
			len_q <= len_d;
			idx_q <= idx_d;
			shift_q <= shift_d;
			mac_q <= mac_d;
			yip_q <= yip_d;
			cip_q <= cip_d;
			rip_q <= rip_d;
			rip_ok_q <= rip_ok_d;
			mt_q <= mt_d;
			mt_ok_q <= mt_ok_d;
			hn_seen_q <= hn_seen_d;
			hn_len_q <= hn_len_d;
			hn_cut_q <= hn_cut_d;
			status_q <= status_d;
		end
	end

endmodule

/* rtl/dpfe_fifo.sv */
module dpfe_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dpfe_pkg::summary_t push_data,
	input  logic               pop,
	output dpfe_pkg::summary_t head,
	output logic               not_empty,
	output logic               not_full
);

	dpfe_pkg::summary_t entry_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         count_q;

	assign head = entry_q[rd_ptr_q];
	assign not_empty = count_q != 2'd0;
	assign not_full = count_q != 2'd2;

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

/* rtl/dpfe_back.sv */
module dpfe_back #(
	parameter int HOSTNAME_MAX = dpfe_pkg::HOSTNAME_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dpfe_pkg::hn_wr_t   hn_wr,
	input  dpfe_pkg::summary_t head,
	input  logic               not_empty,
	output logic               pop,
	dpfe_result_if.source      result_ch
);

	localparam int DEPTH = 2 * HOSTNAME_MAX;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]                   hn_mem [DEPTH];
	logic [dpfe_pkg::HN_CNT_W-1:0] res_idx_q, rd_idx;
	logic [ADDR_W-1:0]            wr_addr, rd_addr;
	logic [7:0]                   rd_q;
	logic                         load, last_res;
	logic                         valid_q;
	dpfe_pkg::summary_t           sum_s1;
	logic                         is_sum_s1, last_s1;

	assign wr_addr = ADDR_W'(hn_wr.idx) + (hn_wr.bank ? ADDR_W'(HOSTNAME_MAX) : ADDR_W'(0));
	assign rd_idx = res_idx_q - 1'b1;
	assign rd_addr = ADDR_W'(rd_idx) + (head.bank ? ADDR_W'(HOSTNAME_MAX) : ADDR_W'(0));

	assign load = not_empty && (!valid_q || result_ch.ready);
	assign last_res = res_idx_q == head.hn_count;
	assign pop = load && last_res;

	always_ff @(posedge clk) begin
		if (hn_wr.en) hn_mem[wr_addr] <= hn_wr.data;
		if (load && res_idx_q != '0) rd_q <= hn_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (res_idx_q == '0) sum_s1 <= head;
			else sum_s1 <= '0;
			is_sum_s1 <= res_idx_q == '0;
			last_s1 <= last_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			res_idx_q <= '0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (result_ch.ready) valid_q <= 1'b0;
			if (load) res_idx_q <= last_res ? '0 : res_idx_q + 1'b1;
		end
	end

	assign result_ch.valid = valid_q;
	assign result_ch.status = sum_s1.status;
	assign result_ch.mac_address = sum_s1.mac_address;
	assign result_ch.ip_address = sum_s1.ip_address;
	assign result_ch.ip_present = sum_s1.ip_present;
	assign result_ch.msg_type = sum_s1.msg_type;
	assign result_ch.msg_type_present = sum_s1.msg_type_present;
	assign result_ch.hostname_present = sum_s1.hostname_present;
	assign result_ch.hostname_length = sum_s1.hostname_length;
	assign result_ch.hostname_truncated = sum_s1.hostname_truncated;
	assign result_ch.hostname_char = is_sum_s1 ? 8'd0 : rd_q;
	assign result_ch.is_summary = is_sum_s1;
	assign result_ch.last_of_run = last_s1;

endmodule

/* rtl/dhcp_payload_field_extractor.sv */
// DHCP payload parser. Takes one payload byte per cycle while the summary queue is not full
// (ports with the first byte) and, on the last byte, queues one summary: status, client MAC,
// chosen IP address, message type and hostname details. The summary goes out first, followed
// by one result per stored hostname byte when the status is good. The result side drains one
// result per cycle while the receiver is ready. Hostname bytes sit in a two-bank store, one
// bank per packet, so the next packet is parsed while the previous one drains; a two-entry
// summary queue stalls input only when two finished packets still wait for their results to
// be taken.
module dhcp_payload_field_extractor #(
	parameter int HOSTNAME_MAX = dpfe_pkg::HOSTNAME_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data,
	dpfe_byte_if.sink     byte_ch,
	dpfe_result_if.source result_ch
);

	logic               push, pop, not_empty, not_full;
	dpfe_pkg::summary_t push_data, head;
	dpfe_pkg::hn_wr_t   hn_wr;

	dpfe_front #(.HOSTNAME_MAX(HOSTNAME_MAX)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_ch    (byte_ch),
		.q_not_full (not_full),
		.push       (push),
		.push_data  (push_data),
		.hn_wr      (hn_wr)
	);

	dpfe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.not_full  (not_full)
	);

	dpfe_back #(.HOSTNAME_MAX(HOSTNAME_MAX)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.hn_wr     (hn_wr),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.result_ch (result_ch)
	);

endmodule
